[sv/slrc_pkg.sv]
package slrc_pkg;

  // Field widths
  localparam int unsigned ChW     = 21;
  localparam int unsigned MixW    = 22;
  localparam int unsigned SampleW = 16;
  localparam int unsigned StepW   = 23;
  localparam int unsigned PhaseW  = 24;
  localparam int unsigned FracW   = 15;

  // Phase constants, 8.16 fixed point (steps 7.16)
  localparam logic [PhaseW-1:0] PhaseOne  = 24'h01_0000;
  localparam logic [StepW-1:0]  StepMin   = 23'd1024;
  localparam logic [StepW-1:0]  StepReset = 23'd73882;

  localparam logic signed [MixW-1:0] SatMax = 22'sd32767;
  localparam logic signed [MixW-1:0] SatMin = -22'sd32768;

  typedef logic signed [SampleW-1:0] sample_t;

  // Clamp a wide signed value to the 16-bit sample range
  function automatic sample_t sat16(input logic signed [MixW-1:0] v);
    sample_t r;
    if (v > SatMax) begin
      r = sample_t'(SatMax);
    end else if (v < SatMin) begin
      r = sample_t'(SatMin);
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/slrc_interp_unit.sv]
// Shared interpolation datapath: prev + floor((cur - prev) * frac / 2^15), saturated
module slrc_interp_unit (
  input  slrc_pkg::sample_t              prev_i,
  input  slrc_pkg::sample_t              cur_i,
  input  logic [slrc_pkg::FracW-1:0]     frac_i,
  output slrc_pkg::sample_t              res_o
);
  import slrc_pkg::*;

  logic signed [SampleW:0]   diff;
  logic signed [FracW:0]     frac_s;
  logic signed [SampleW+FracW+1:0] prod;
  logic signed [SampleW+1:0] shifted;
  logic signed [SampleW+2:0] sum;

  // Difference times fraction; dropping the low bits is a floor shift
  assign diff    = $signed({cur_i[SampleW-1], cur_i}) - $signed({prev_i[SampleW-1], prev_i});
  assign frac_s  = $signed({1'b0, frac_i});
  assign prod    = (SampleW+FracW+2)'(diff) * (SampleW+FracW+2)'(frac_s);
  assign shifted = prod[SampleW+FracW+1:FracW];
  assign sum     = (SampleW+3)'(shifted) + (SampleW+3)'(prev_i);
  assign res_o   = sat16(MixW'(sum));

endmodule

[sv/stereo_linear_rate_converter_top.sv]
// Flow: after the input transaction the block steps through left product, right
// product and send for each frame, holding in send while the output side is not ready.
// No new input is taken until the last frame is sent; frames 0..64 per input, set by phase_step;
// the single shared multiplier serves left and right in turn.
// Reset: rst_ni asynchronous, clears the sample pair, phase and fill count and loads
// phase_step with 73882; the block is ready on the first cycle after reset.
module stereo_linear_rate_converter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: phase_step
  input  logic                         cfg_we_i,
  input  logic [slrc_pkg::StepW-1:0]   cfg_wdata_i,
  // Input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [87:0]                  s_axis_tdata_i,  // ch_a, ch_b, ch_c, ch_d, zero pad
  // Output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [31:0]                  m_axis_tdata_o,  // left, right
  output logic                         m_axis_tlast_o
);
  import slrc_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StLeft  = 2'd1;
  localparam logic [1:0] StRight = 2'd2;
  localparam logic [1:0] StSend  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [StepW-1:0]  step_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        fill_q, fill_d;
  sample_t           prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  sample_t           new_l_q, new_r_q;
  sample_t           left_q, right_q;
  logic              last_q;

  logic              in_hs, out_hs, shift_in, shift_pend;
  logic signed [MixW-1:0] sum_l, sum_r;
  sample_t           mix_l, mix_r;
  logic [StepW-1:0]  step_eff;
  logic [PhaseW-1:0] phase_sum;
  sample_t           unit_prev, unit_cur, unit_res;

  assign in_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;

  // Input mix: halve with truncation toward zero, then clamp
  assign sum_l = MixW'($signed(s_axis_tdata_i[20:0])) + MixW'($signed(s_axis_tdata_i[62:42]));
  assign sum_r = MixW'($signed(s_axis_tdata_i[41:21])) + MixW'($signed(s_axis_tdata_i[83:63]));
  assign mix_l = sat16((sum_l + MixW'($signed({1'b0, sum_l[MixW-1]}))) >>> 1);
  assign mix_r = sat16((sum_r + MixW'($signed({1'b0, sum_r[MixW-1]}))) >>> 1);

  // Step floor and phase advance
  assign step_eff  = (step_q < StepMin) ? StepMin : step_q;
  assign phase_sum = phase_q + PhaseW'(step_eff);

  // Shared interpolation unit, left in StLeft, right in StRight
  assign unit_prev = (state_q == StRight) ? prev_r_q : prev_l_q;
  assign unit_cur  = (state_q == StRight) ? cur_r_q  : cur_l_q;

  slrc_interp_unit u_interp (
    .prev_i (unit_prev),
    .cur_i  (unit_cur),
    .frac_i (phase_q[FracW:1]),
    .res_o  (unit_res)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fill_d     = fill_q;
    shift_in   = 1'b0;
    shift_pend = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_hs) begin
          if (fill_q != 2'd2) begin
            fill_d   = fill_q + 2'd1;
            shift_in = 1'b1;
          end else if (phase_q >= PhaseOne) begin
            phase_d  = phase_q - PhaseOne;
            shift_in = 1'b1;
          end else begin
            state_d = StLeft;
          end
        end
      end
      StLeft: begin
        state_d = StRight;
      end
      StRight: begin
        phase_d = phase_sum;
        state_d = StSend;
      end
      StSend: begin
        if (out_hs) begin
          if (last_q) begin
            phase_d    = phase_q - PhaseOne;
            shift_pend = 1'b1;
            state_d    = StIdle;
          end else begin
            state_d = StLeft;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= StepReset;
      phase_q  <= '0;
      fill_q   <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      cur_l_q  <= '0;
      cur_r_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (shift_in) begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
        cur_l_q  <= mix_l;
        cur_r_q  <= mix_r;
      end else if (shift_pend) begin
        prev_l_q <= cur_l_q;
        prev_r_q <= cur_r_q;
        cur_l_q  <= new_l_q;
        cur_r_q  <= new_r_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      new_l_q <= mix_l;
      new_r_q <= mix_r;
    end
    if (state_q == StLeft) begin
      left_q <= unit_res;
    end
    if (state_q == StRight) begin
      right_q <= unit_res;
      last_q  <= (phase_sum >= PhaseOne);
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StSend);
  assign m_axis_tdata_o  = {right_q, left_q};
  assign m_axis_tlast_o  = last_q;

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a frame is pending");

  a_mid_frame_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (phase_q < PhaseOne))
    else $error("non-final frame with phase at or above one");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("not ready after final frame transaction");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("fill count overran");

endmodule

[verif/stereo_linear_rate_converter_top_test.sv]
module stereo_linear_rate_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slrc_pkg::*;

  typedef logic signed [ChW-1:0] chan_t;

  // One stereo output frame as it leaves the block
  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } frame_t;

  // One row of directed stimulus; fixed rows carry a hand-written expectation
  typedef struct packed {
    chan_t   a;
    chan_t   b;
    chan_t   c;
    chan_t   d;
    logic    fixed;
    logic    one_frame;
    sample_t l;
    sample_t r;
  } stim_row_t;

  localparam chan_t ChanMax     = 21'sh0F_FFFF;
  localparam chan_t ChanMin     = 21'sh10_0000;
  localparam int    FramesMax   = 64;
  localparam int    DrainCycles = 200;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [StepW-1:0]    cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [87:0]         s_axis_tdata_i  = '0;  // ch_a, ch_b, ch_c, ch_d, zero pad
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [31:0]         m_axis_tdata_o;        // left, right
  logic                m_axis_tlast_o;

  stereo_linear_rate_converter_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock, 8 ns period
  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  // Converter state mirrored in the testbench
  logic [StepW-1:0]  step_reg = StepReset;
  sample_t           prev_l = '0, prev_r = '0, cur_l = '0, cur_r = '0;
  logic [PhaseW-1:0] phase_acc = '0;
  int                fill_cnt = 0;

  frame_t    frames_q[$];   // frames still owed by the block
  stim_row_t dir_q[$];
  int        n_errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic sample_t clamp16(input longint v);
    if (v > 32767) return sample_t'(16'sh7FFF);
    if (v < -32768) return sample_t'(16'sh8000);
    return sample_t'(v);
  endfunction

  // Average of two channels, truncated toward zero, then clamped
  function automatic sample_t mix_pair(input chan_t x, input chan_t y);
    longint s;
    s = longint'(x) + longint'(y);
    return clamp16(s / 2);
  endfunction

  // Linear step from p towards c by f/32768, floor rounding
  function automatic sample_t lerp(input sample_t p, input sample_t c, input logic [14:0] f);
    longint prod;
    prod = (longint'(c) - longint'(p)) * longint'(f);
    return clamp16(longint'(p) + (prod >>> 15));
  endfunction

  // Frames one native sample produces; advances the mirrored state
  function automatic void convert_sample(input chan_t a, input chan_t b, input chan_t c,
                                         input chan_t d, output frame_t out[$]);
    sample_t           l, r;
    logic [StepW-1:0]  stp;
    logic [PhaseW-1:0] nxt;
    frame_t            fr;
    int                n;
    out = {};
    l = mix_pair(a, c);
    r = mix_pair(b, d);
    n = 0;
    if (fill_cnt >= 2) begin
      stp = (step_reg < StepMin) ? StepMin : step_reg;
      while (phase_acc < PhaseOne && n < FramesMax) begin
        fr.left  = lerp(prev_l, cur_l, phase_acc[15:1]);
        fr.right = lerp(prev_r, cur_r, phase_acc[15:1]);
        nxt      = phase_acc + PhaseW'(stp);
        fr.last  = !(nxt < PhaseOne && n + 1 < FramesMax);
        out.push_back(fr);
        n++;
        phase_acc = nxt;
      end
      phase_acc = phase_acc - PhaseOne;
    end else begin
      fill_cnt++;
    end
    prev_l = cur_l;
    prev_r = cur_r;
    cur_l  = l;
    cur_r  = r;
  endfunction

  function automatic chan_t rand_chan();
    case ($urandom_range(0, 3))
      0: return chan_t'($urandom);
      1: return chan_t'(int'($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(0, 1) ? ChanMax : ChanMin;
      default: return chan_t'(int'($urandom_range(0, 140000)) - 70000);
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    row = '0;
    row.a = rand_chan();
    row.b = rand_chan();
    row.c = rand_chan();
    row.d = rand_chan();
    return row;
  endfunction

  task automatic add_row(input chan_t a, input chan_t b, input chan_t c, input chan_t d,
                         input logic fixed, input logic one_frame,
                         input sample_t l, input sample_t r);
    stim_row_t row;
    row = {a, b, c, d, fixed, one_frame, l, r};
    dir_q.push_back(row);
  endtask

  // Offer one sample; valid stays high into the next call unless the sender idles
  task automatic send_sample(input stim_row_t row);
    frame_t fr;
    frame_t owed[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i  <= {4'b0, row.d, row.c, row.b, row.a};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    convert_sample(row.a, row.b, row.c, row.d, owed);
    if (row.fixed) begin
      if (row.one_frame) begin
        fr = {row.l, row.r, 1'b1};
        frames_q.push_back(fr);
      end
    end else begin
      foreach (owed[i]) frames_q.push_back(owed[i]);
    end
  endtask

  task automatic drain();
    while (frames_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // New phase_step once idle, then a burst of random samples
  task automatic run_phase(input logic [StepW-1:0] stp, input int count);
    s_axis_tvalid_i <= 1'b0;
    drain();
    cfg_wdata_i <= stp;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    step_reg = stp;
    repeat (count) send_sample(rand_row());
  endtask

  // Output side stalls
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each output transaction with the oldest owed frame
  always @(posedge clk_i) begin
    frame_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tlast_o};
      if (frames_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected frame, expected none, got left %0d right %0d last %0b",
                 $time, got.left, got.right, got.last);
      end else begin
        want = frames_q.pop_front();
        if (got.left !== want.left) begin
          n_errors++;
          $display("%0t: left mismatch, expected %0d, got %0d", $time, want.left, got.left);
        end
        if (got.right !== want.right) begin
          n_errors++;
          $display("%0t: right mismatch, expected %0d, got %0d", $time, want.right, got.right);
        end
        if (got.last !== want.last) begin
          n_errors++;
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
        end
      end
    end
  end

  // Stimulus
  initial begin
    // Filling: two samples give nothing; the third repeats the first sample
    add_row(ChanMax, ChanMin, ChanMax, ChanMin, 1'b1, 1'b0, '0, '0);
    add_row(ChanMax, ChanMin, ChanMin, ChanMax, 1'b1, 1'b0, '0, '0);
    add_row('0, '0, '0, '0, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000);
    // Truncation toward zero on odd negative sums
    add_row(21'sd3, -21'sd3, 21'sd0, 21'sd0, 1'b0, 1'b0, '0, '0);
    add_row(21'sd65535, -21'sd65537, 21'sd1, -21'sd1, 1'b0, 1'b0, '0, '0);
    add_row(21'sd65533, -21'sd65535, 21'sd0, 21'sd0, 1'b0, 1'b0, '0, '0);
    add_row(21'sh15_5555, 21'sh0A_AAAA, 21'sh0A_AAAA, 21'sh15_5555, 1'b0, 1'b0, '0, '0);
    add_row(-21'sd1, -21'sd1, -21'sd1, -21'sd1, 1'b0, 1'b0, '0, '0);
    add_row(21'sd1000, 21'sd12345, -21'sd20000, 21'sd6789, 1'b0, 1'b0, '0, '0);
    // Full-scale swings, both directions
    add_row(ChanMin, ChanMax, ChanMin, ChanMax, 1'b0, 1'b0, '0, '0);
    add_row(ChanMax, ChanMin, ChanMax, ChanMin, 1'b0, 1'b0, '0, '0);
    add_row(ChanMin, ChanMax, ChanMin, ChanMax, 1'b0, 1'b0, '0, '0);
    add_row(21'sd65534, -21'sd65536, 21'sd0, 21'sd0, 1'b0, 1'b0, '0, '0);
    add_row(-21'sd65536, 21'sd65534, 21'sd0, 21'sd0, 1'b0, 1'b0, '0, '0);
    add_row(21'sd1, 21'sd0, 21'sd0, 21'sd1, 1'b0, 1'b0, '0, '0);
    add_row(21'sd300, -21'sd300, 21'sd301, -21'sd301, 1'b0, 1'b0, '0, '0);
    add_row(ChanMax, ChanMax, ChanMin, ChanMin, 1'b0, 1'b0, '0, '0);
    add_row(21'sd40000, -21'sd40000, 21'sd40000, -21'sd40000, 1'b0, 1'b0, '0, '0);
    add_row(-21'sd7, 21'sd9, 21'sd2, -21'sd4, 1'b0, 1'b0, '0, '0);
    add_row('0, '0, '0, '0, 1'b0, 1'b0, '0, '0);

    send_idle_pct = 11;
    recv_idle_pct = 78;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset step
    foreach (dir_q[i]) send_sample(dir_q[i]);

    // Smallest steps: 64 frames per sample
    run_phase('0, 6);
    run_phase(StepW'(1023), 6);
    run_phase(StepW'(1024), 6);

    send_idle_pct = 78;
    recv_idle_pct = 11;
    // Largest step: frames are rare
    run_phase(StepW'(8388607), 30);
    run_phase(StepW'(65536), 16);
    run_phase(StepW'(4096), 10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(StepW'(98304), 12);
    run_phase(StepReset, 12);
    run_phase(StepW'($urandom_range(1024, 200000)), 12);

    s_axis_tvalid_i <= 1'b0;
    drain();
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
